[sv/pbsq_pkg.sv]
`default_nettype none
package pbsq_pkg;

   // shared multiplier operand width and product width
   localparam int MUL_W  = 32;
   localparam int PROD_W = 2 * MUL_W;

   // step-correction arithmetic: Q.30 argument, signed Q.30 sum
   localparam int FRAC_W = 30;
   localparam int SUM_W  = 33;
   localparam logic [FRAC_W:0] Q30_ONE = 31'h4000_0000;

   // 0.707 as Q0.16
   localparam logic [15:0] GAIN_0707 = 16'd46334;

   // register file
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam logic [1:0] REG_PHASE_STEP  = 2'd0;
   localparam logic [1:0] REG_PHASE_RECIP = 2'd1;
   localparam logic [1:0] REG_PULSE_WIDTH = 2'd2;
   localparam logic [1:0] REG_AMPLITUDE   = 2'd3;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ARG1,
      ST_SQR1,
      ST_ARG2,
      ST_SQR2,
      ST_SUM,
      ST_GAIN,
      ST_AMP,
      ST_DONE
   } pbsq_state_type;

   typedef enum logic [2:0] {
      MUL_HOLD,
      MUL_ARG,
      MUL_SQR,
      MUL_GAIN,
      MUL_AMP
   } pbsq_mul_op_type;

   typedef struct packed {
      logic            load;    // take the input word, advance the phase
      pbsq_mul_op_type mul_op;  // what the shared multiplier works on
      logic            sel_t2;  // correction at the falling edge
      logic            acc;     // add the finished correction into the sum
      logic            finish;  // load the output register
   } pbsq_cmd_type;

   typedef struct packed {
      logic out_free;
   } pbsq_status_type;

endpackage
`default_nettype wire

[sv/pbsq_csr.sv]
`default_nettype none
module pbsq_csr #(
   parameter int PHASE_BITS = 24
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_psel,
   input  wire logic                             csr_penable,
   input  wire logic                             csr_pwrite,
   input  wire logic [pbsq_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  wire logic [pbsq_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic      [pbsq_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                                  csr_pready,
   output logic      [PHASE_BITS-1:0]            phase_step,
   output logic      [31:0]                      phase_step_recip,
   output logic      [PHASE_BITS-1:0]            pulse_width,
   output logic      [15:0]                      amplitude
);
   import pbsq_pkg::*;

   logic [PHASE_BITS-1:0] step_ff, step_in;
   logic [31:0]           recip_ff, recip_in;
   logic [PHASE_BITS-1:0] pw_ff, pw_in;
   logic [15:0]           amp_ff, amp_in;
   logic                  wr_en;
   logic [1:0]            reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign reg_idx    = csr_paddr[3:2];

   // write decode
   always_comb begin
      step_in  = step_ff;
      recip_in = recip_ff;
      pw_in    = pw_ff;
      amp_in   = amp_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_PHASE_STEP:  step_in  = csr_pwdata[PHASE_BITS-1:0];
            REG_PHASE_RECIP: recip_in = csr_pwdata[31:0];
            REG_PULSE_WIDTH: pw_in    = csr_pwdata[PHASE_BITS-1:0];
            REG_AMPLITUDE:   amp_in   = csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= '0;
         recip_ff <= '0;
         pw_ff    <= PHASE_BITS'(1) << (PHASE_BITS - 1);
         amp_ff   <= 16'd32768;
      end else begin
         step_ff  <= step_in;
         recip_ff <= recip_in;
         pw_ff    <= pw_in;
         amp_ff   <= amp_in;
      end
   end

   // read back
   always_comb begin
      unique case (reg_idx)
         REG_PHASE_STEP:  csr_prdata = CSR_DATA_W'(step_ff);
         REG_PHASE_RECIP: csr_prdata = CSR_DATA_W'(recip_ff);
         REG_PULSE_WIDTH: csr_prdata = CSR_DATA_W'(pw_ff);
         REG_AMPLITUDE:   csr_prdata = CSR_DATA_W'(amp_ff);
         default:         csr_prdata = '0;
      endcase
   end

   assign phase_step       = step_ff;
   assign phase_step_recip = recip_ff;
   assign pulse_width      = pw_ff;
   assign amplitude        = amp_ff;

endmodule
`default_nettype wire

[sv/pbsq_ctrl.sv]
`default_nettype none
module pbsq_ctrl (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire pbsq_pkg::pbsq_status_type status,
   output pbsq_pkg::pbsq_cmd_type         cmd
);
   import pbsq_pkg::*;

   pbsq_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // sequencer: one multiplier pass per step, but for the SUM and DONE steps
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      cmd.mul_op = MUL_HOLD;
      req_stall  = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_ARG1;
            end
         end
         ST_ARG1: begin
            cmd.mul_op = MUL_ARG;
            state_in   = ST_SQR1;
         end
         ST_SQR1: begin
            cmd.mul_op = MUL_SQR;
            state_in   = ST_ARG2;
         end
         ST_ARG2: begin
            cmd.mul_op = MUL_ARG;
            cmd.sel_t2 = 1'b1;
            cmd.acc    = 1'b1;
            state_in   = ST_SQR2;
         end
         ST_SQR2: begin
            cmd.mul_op = MUL_SQR;
            state_in   = ST_SUM;
         end
         ST_SUM: begin
            cmd.acc  = 1'b1;
            state_in = ST_GAIN;
         end
         ST_GAIN: begin
            cmd.mul_op = MUL_GAIN;
            state_in   = ST_AMP;
         end
         ST_AMP: begin
            cmd.mul_op = MUL_AMP;
            state_in   = ST_DONE;
         end
         ST_DONE: begin
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   a_load_starts: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> state_ff == ST_ARG1)
      else $error("sequencer did not start after a load");

   a_done_waits: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DONE && !status.out_free |=> state_ff == ST_DONE)
      else $error("result dropped while output register busy");

   a_cmd_exclusive: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.acc, cmd.finish}))
      else $error("conflicting datapath commands");

endmodule
`default_nettype wire

[sv/pbsq_dp.sv]
`default_nettype none
module pbsq_dp #(
   parameter int PHASE_BITS  = 24,
   parameter int SAMPLE_BITS = 16
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire pbsq_pkg::pbsq_cmd_type    cmd,
   output pbsq_pkg::pbsq_status_type      status,
   input  wire logic [PHASE_BITS-1:0]     phase_step,
   input  wire logic [31:0]               phase_step_recip,
   input  wire logic [PHASE_BITS-1:0]     pulse_width,
   input  wire logic [15:0]               amplitude,
   input  wire logic [PHASE_BITS-1:0]     req_phase_offset,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output logic signed [SAMPLE_BITS-1:0]  rsp_sample,
   output logic                           rsp_end_of_cycle
);
   import pbsq_pkg::*;

   localparam int ARG_SH = PHASE_BITS - 14;   // product to Q.30
   localparam int XW     = PROD_W - ARG_SH;
   localparam int OUT_SH = 46 - SAMPLE_BITS;  // Q.45 product to Q1.(S-1)
   localparam int RW     = 49;

   // phase state and per-word registers
   logic [PHASE_BITS-1:0]   acc_ff, acc_in;
   logic [PHASE_BITS:0]     acc_next;
   logic [PHASE_BITS-1:0]   t_ff, t2_ff, t_mod;
   logic                    eoc_ff;
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic [PROD_W-1:0]       prod_ff, prod_in;
   logic                    neg_ff, act_ff;

   // output register
   logic                          rsp_valid_ff;
   logic signed [SAMPLE_BITS-1:0] rsp_sample_ff;
   logic                          rsp_eoc_ff;

   // correction region of the selected phase
   logic [PHASE_BITS-1:0] cur, phase_dist;
   logic [PHASE_BITS:0]   cur_plus;
   logic                  reg_lo, reg_hi;

   // multiplier operands and helpers
   logic [MUL_W-1:0]        mul_a, mul_b;
   logic [XW-1:0]           x_full;
   logic [FRAC_W:0]         x_sat, u_val, c_val;
   logic signed [SUM_W-1:0] c_term;
   logic [SUM_W-1:0]        mag_full;
   logic [RW-1:0]           rnd16, rnd_out, q_out, q_sat, lim;
   logic [MUL_W-1:0]        gain_mag;
   logic                    out_neg;
   logic [SAMPLE_BITS-1:0]  mag_s;

   // input word: modulated phase, falling-edge phase, naive level, phase advance
   assign t_mod    = acc_ff + req_phase_offset;
   assign acc_next = {1'b0, acc_ff} + {1'b0, phase_step};
   assign acc_in   = cmd.load ? acc_next[PHASE_BITS-1:0] : acc_ff;

   // region select
   assign cur        = cmd.sel_t2 ? t2_ff : t_ff;
   assign cur_plus   = {1'b0, cur} + {1'b0, phase_step};
   assign reg_lo     = cur < phase_step;
   assign reg_hi     = !reg_lo && (cur_plus > ((PHASE_BITS+1)'(1) << PHASE_BITS));
   assign phase_dist = reg_lo ? cur : PHASE_BITS'(0) - cur;

   // argument saturation and 1 - x
   assign x_full = prod_ff[PROD_W-1:ARG_SH];
   assign x_sat  = (x_full > XW'(Q30_ONE)) ? Q30_ONE : x_full[FRAC_W:0];
   assign u_val  = Q30_ONE - x_sat;

   // finished square back to Q.30, signed for the sum
   assign c_val  = prod_ff[2*FRAC_W:FRAC_W];
   assign c_term = neg_ff ? -$signed({2'b00, c_val}) : $signed({2'b00, c_val});
   assign sum_in = act_ff ? sum_ff + c_term : sum_ff;

   // magnitude and the two rounding steps
   assign mag_full = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
   assign rnd16    = {1'b0, prod_ff[47:0]} + RW'(32768);
   assign gain_mag = rnd16[47:16];
   assign rnd_out  = {1'b0, prod_ff[47:0]} + (RW'(1) << (OUT_SH - 1));
   assign q_out    = rnd_out >> OUT_SH;
   assign out_neg  = sum_ff[SUM_W-1];
   assign lim      = RW'(1) << (SAMPLE_BITS - 1);

   // saturate to the output range
   always_comb begin
      q_sat = q_out;
      if (!out_neg && q_out > lim - RW'(1)) begin
         q_sat = lim - RW'(1);
      end else if (out_neg && q_out > lim) begin
         q_sat = lim;
      end
   end
   assign mag_s = q_sat[SAMPLE_BITS-1:0];

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (cmd.mul_op)
         MUL_HOLD: ;
         MUL_ARG: begin
            mul_a = MUL_W'(phase_dist);
            mul_b = phase_step_recip;
         end
         MUL_SQR: begin
            mul_a = MUL_W'(u_val);
            mul_b = MUL_W'(u_val);
         end
         MUL_GAIN: begin
            mul_a = mag_full[MUL_W-1:0];
            mul_b = MUL_W'(GAIN_0707);
         end
         MUL_AMP: begin
            mul_a = gain_mag;
            mul_b = MUL_W'(amplitude);
         end
         default: ;
      endcase
   end
   assign prod_in = (cmd.mul_op == MUL_HOLD) ? prod_ff
                                             : PROD_W'(mul_a) * PROD_W'(mul_b);

   // phase accumulator
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else begin
         acc_ff <= acc_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (cmd.load) begin
         t_ff   <= t_mod;
         t2_ff  <= t_mod - pulse_width;
         eoc_ff <= acc_next[PHASE_BITS];
         sum_ff <= (t_mod < pulse_width) ? $signed(SUM_W'(Q30_ONE))
                                         : -$signed(SUM_W'(Q30_ONE));
      end else if (cmd.acc) begin
         sum_ff <= sum_in;
      end
      if (cmd.mul_op == MUL_ARG) begin
         neg_ff <= reg_lo ^ cmd.sel_t2;
         act_ff <= reg_lo | reg_hi;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.finish) begin
         rsp_sample_ff <= out_neg ? -$signed(mag_s) : $signed(mag_s);
         rsp_eoc_ff    <= eoc_ff;
      end
   end

   assign status.out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sample       = rsp_sample_ff;
   assign rsp_end_of_cycle = rsp_eoc_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> !(rsp_valid_ff && rsp_stall))
      else $error("output register overwritten while held");

   a_phase_advance: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> acc_ff == PHASE_BITS'($past(acc_ff) + $past(phase_step)))
      else $error("phase did not advance by one step");

   a_phase_still: assert property (@(posedge clock) disable iff (reset)
      !cmd.load |=> $stable(acc_ff))
      else $error("phase moved without an input word");

endmodule
`default_nettype wire

[sv/polyblep_square_oscillator.sv]
`default_nettype none
// channel | direction | handshake              | payload
// req     | in        | req_valid / req_stall  | req_phase_offset
// rsp     | out       | rsp_valid / rsp_stall  | rsp_sample, rsp_end_of_cycle
// csr     | in        | APB write/read, pready | 4 registers at byte address 4*i
//
// A word is accepted in the idle state and then runs eight sequencer steps, six of
// them passes through the shared 32x32 multiplier (two argument products, two
// squares, the 0.707 gain, the amplitude), one to fold in the second correction
// and one to load the output register, after which the registered rsp_valid rises.
// Synchronous reset returns phase, CSR registers, sequencer and rsp_valid to reset values.
// req_stall stays high until the word is done; the last step waits on rsp_stall.
module polyblep_square_oscillator #(
   parameter int PHASE_BITS  = 24,
   parameter int SAMPLE_BITS = 16
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic [PHASE_BITS-1:0]            req_phase_offset,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic signed [SAMPLE_BITS-1:0]         rsp_sample,
   output logic                                  rsp_end_of_cycle,
   input  wire logic                             csr_psel,
   input  wire logic                             csr_penable,
   input  wire logic                             csr_pwrite,
   input  wire logic [pbsq_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  wire logic [pbsq_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic      [pbsq_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                                  csr_pready
);
   import pbsq_pkg::*;

   pbsq_cmd_type          cmd;
   pbsq_status_type       status;
   logic [PHASE_BITS-1:0] phase_step;
   logic [31:0]           phase_step_recip;
   logic [PHASE_BITS-1:0] pulse_width;
   logic [15:0]           amplitude;

   pbsq_csr #(
      .PHASE_BITS (PHASE_BITS)
   ) u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready),
      .phase_step       (phase_step),
      .phase_step_recip (phase_step_recip),
      .pulse_width      (pulse_width),
      .amplitude        (amplitude)
   );

   pbsq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   pbsq_dp #(
      .PHASE_BITS  (PHASE_BITS),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .phase_step       (phase_step),
      .phase_step_recip (phase_step_recip),
      .pulse_width      (pulse_width),
      .amplitude        (amplitude),
      .req_phase_offset (req_phase_offset),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_sample       (rsp_sample),
      .rsp_end_of_cycle (rsp_end_of_cycle)
   );

endmodule
`default_nettype wire
